@@ hw/rtl/afsk_pkg.sv @@
// ----------------------------------------------------------------------------
// afsk_pkg
// Shared types and constants for the AFSK slicer, clock recovery and DCD.
// ----------------------------------------------------------------------------
package afsk_pkg;

    localparam int LEVEL_BITS   = 24;
    localparam int FRAC_BITS    = 16;
    localparam int HISTORY_BITS = 32;

    localparam int COEF_BITS  = 24;
    localparam int IN_BITS    = LEVEL_BITS;
    localparam int NORM_BITS  = 15;
    localparam int PHASE_BITS = 32;
    localparam int STEP_BITS  = 31;
    localparam int CNT_BITS   = 6;

    localparam int DETECT_MARGIN = 3;
    localparam int LOCKED_SHIFT  = 3;
    localparam int SEARCH_SHIFT  = 2;

    localparam logic [PHASE_BITS-1:0] HALF_WINDOW_HI = 32'h3FFF_FFFF;
    localparam logic [PHASE_BITS-1:0] HALF_WINDOW_LO = 32'hC000_0000;

    // register indexes
    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_HYST    = 3'd2;
    localparam logic [2:0] REG_STEP    = 3'd3;
    localparam logic [2:0] REG_CAR_ON  = 3'd4;
    localparam logic [2:0] REG_CAR_OFF = 3'd5;

    localparam logic [COEF_BITS-1:0] ATTACK_RST  = 24'd31715;
    localparam logic [COEF_BITS-1:0] DECAY_RST   = 24'd635;
    localparam logic [NORM_BITS-1:0] HYST_RST    = 15'd33;
    localparam logic [STEP_BITS-1:0] STEP_RST    = 31'd390451572;
    localparam logic [CNT_BITS-1:0]  CAR_ON_RST  = 6'd30;
    localparam logic [CNT_BITS-1:0]  CAR_OFF_RST = 6'd2;

    typedef struct packed {
        logic [IN_BITS-1:0] mark_level;
        logic [IN_BITS-1:0] space_level;
    } t_in_word;

    typedef struct packed {
        logic data_bit;
        logic carrier_detect;
    } t_out_word;

endpackage

@@ hw/rtl/afsk_slicer_clock_recovery_dcd.sv @@
// ----------------------------------------------------------------------------
// afsk_slicer_clock_recovery_dcd
// AFSK bit slicer with per-tone AGC, PLL clock recovery and carrier detect.
// ----------------------------------------------------------------------------
// Input channel: one word per decimated sample (mark and space tone levels),
//   taken when i_in_valid and o_in_ready are both high.
// Output channel: one word (data bit, carrier flag) on each phase wrap of the
//   recovery PLL; most input words produce no output word.
// Each input word keeps o_in_ready low from acceptance until the sequencer is
//   idle again: the four peak/valley trackers (ST_MHI, ST_MLO and ST_TRK each,
//   two passes of one shared multiplier), each tone normalization on one shared
//   restoring divider (setup plus 15 steps; setup only when the tone range is
//   empty or the value saturates), slicer and phase, carrier update and output
//   when a bit is due, and transition. A new word is taken only after the last
//   one is through. o_in_ready is high only while idle.
// The output word sits in a register; if it has not been taken when the
//   next one is due, the sequencer waits on it, holding o_in_ready low.
// Reset clears all tracker levels, the phase, histories and the carrier flag
//   and loads the default configuration. The user must write registers over the
//   APB-style port only while idle, unchecked by the block; pready is always high.
// ----------------------------------------------------------------------------
module afsk_slicer_clock_recovery_dcd
    import afsk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int LW  = LEVEL_BITS + FRAC_BITS;
    localparam int HW  = (LW > COEF_BITS) ? (LW - COEF_BITS) : 1;
    localparam int MW  = (HW > COEF_BITS) ? HW : COEF_BITS;
    localparam int CW  = $clog2(HISTORY_BITS + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MHI  = 4'd1;
    localparam logic [3:0] ST_MLO  = 4'd2;
    localparam logic [3:0] ST_TRK  = 4'd3;
    localparam logic [3:0] ST_NSET = 4'd4;
    localparam logic [3:0] ST_NDIV = 4'd5;
    localparam logic [3:0] ST_PH   = 4'd6;
    localparam logic [3:0] ST_DET  = 4'd7;
    localparam logic [3:0] ST_CAR  = 4'd8;
    localparam logic [3:0] ST_TRN  = 4'd9;

    function automatic logic [CW-1:0] f_pop(input logic [HISTORY_BITS-1:0] v);
        logic [CW-1:0] n;
        n = '0;
        for (int i = 0; i < HISTORY_BITS; i++) begin
            n = n + CW'(v[i]);
        end
        return n;
    endfunction

    // configuration
    logic [COEF_BITS-1:0] r_attack, r_decay;
    logic [NORM_BITS-1:0] r_hyst;
    logic [STEP_BITS-1:0] r_step;
    logic [CNT_BITS-1:0]  r_car_on, r_car_off;

    // state
    logic [3:0]              r_state;
    logic [1:0]              r_idx;
    logic                    r_side;
    logic [3:0]              r_cnt;
    logic [LW-1:0]           r_xm, r_xs;
    logic [LW-1:0]           r_mh, r_ml, r_sh, r_sl;
    logic [LW-1:0]           r_acc;
    logic [2*COEF_BITS-1:0]  r_prod;
    logic [LW+1:0]           r_rem;
    logic [LW:0]             r_den;
    logic                    r_neg;
    logic [NORM_BITS-1:0]    r_q;
    logic signed [15:0]      r_nm, r_ns;
    logic                    r_sym, r_prev_sym;
    logic [PHASE_BITS-1:0]   r_phase;
    logic                    r_good_p, r_bad_p;
    logic [HISTORY_BITS-1:0] r_good_h, r_bad_h, r_det_h;
    logic                    r_carrier;
    logic                    r_out_valid;
    t_out_word               r_out;

    logic cfg_wr;
    assign cfg_wr   = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;

    always_comb begin
        unique case (i_paddr[4:2])
            REG_ATTACK:  o_prdata = 32'(r_attack);
            REG_DECAY:   o_prdata = 32'(r_decay);
            REG_HYST:    o_prdata = 32'(r_hyst);
            REG_STEP:    o_prdata = 32'(r_step);
            REG_CAR_ON:  o_prdata = 32'(r_car_on);
            REG_CAR_OFF: o_prdata = 32'(r_car_off);
            default:     o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= ATTACK_RST;
            r_decay   <= DECAY_RST;
            r_hyst    <= HYST_RST;
            r_step    <= STEP_RST;
            r_car_on  <= CAR_ON_RST;
            r_car_off <= CAR_OFF_RST;
        end else if (cfg_wr) begin
            unique case (i_paddr[4:2])
                REG_ATTACK:  r_attack  <= i_pwdata[COEF_BITS-1:0];
                REG_DECAY:   r_decay   <= i_pwdata[COEF_BITS-1:0];
                REG_HYST:    r_hyst    <= i_pwdata[NORM_BITS-1:0];
                REG_STEP:    r_step    <= i_pwdata[STEP_BITS-1:0];
                REG_CAR_ON:  r_car_on  <= i_pwdata[CNT_BITS-1:0];
                REG_CAR_OFF: r_car_off <= i_pwdata[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // tracker operand selection
    logic [LW-1:0]           t_lvl, t_x, t_m, t_sc, t_new;
    logic                    t_up, t_out;
    logic [COEF_BITS-1:0]    t_coef;
    logic [LW+COEF_BITS-1:0] t_mext;
    logic [HW-1:0]           t_mhi;
    logic [MW-1:0]           t_mop;
    logic [MW+COEF_BITS-1:0] t_prd;

    always_comb begin
        unique case (r_idx)
            2'd0:    t_lvl = r_mh;
            2'd1:    t_lvl = r_ml;
            2'd2:    t_lvl = r_sh;
            default: t_lvl = r_sl;
        endcase
        t_x    = r_idx[1] ? r_xs : r_xm;
        t_out  = r_idx[0] ? (t_x < t_lvl) : (t_x > t_lvl);
        t_coef = t_out ? r_attack : r_decay;
        t_up   = (t_x >= t_lvl);
        t_m    = t_up ? (t_x - t_lvl) : (t_lvl - t_x);
        t_mext = (LW + COEF_BITS)'(t_m);
        t_mhi  = HW'(t_mext >> COEF_BITS);
        // high part in ST_MHI, low part in ST_MLO
        t_mop  = (r_state == ST_MLO) ? MW'(t_mext[COEF_BITS-1:0]) : MW'(t_mhi);
        t_prd  = (MW + COEF_BITS)'(t_mop) * (MW + COEF_BITS)'(t_coef);
        t_sc   = r_acc + LW'(r_prod >> COEF_BITS);
        t_new  = t_up ? (t_lvl + t_sc) : (t_lvl - t_sc);
    end

    // normalization setup
    logic [LW-1:0] s_hi, s_lo, s_x;
    logic [LW:0]   s_sum, s_x2, s_den, s_mag;
    logic          s_neg;

    always_comb begin
        s_hi  = r_side ? r_sh : r_mh;
        s_lo  = r_side ? r_sl : r_ml;
        s_x   = r_side ? r_xs : r_xm;
        s_sum = (LW + 1)'(s_hi) + (LW + 1)'(s_lo);
        s_x2  = {s_x, 1'b0};
        s_den = {s_hi - s_lo, 1'b0};
        s_neg = (s_x2 < s_sum);
        s_mag = s_neg ? (s_sum - s_x2) : (s_x2 - s_sum);
    end

    // divider step
    logic [LW+1:0]        d_sh;
    logic                 d_ge;
    logic [NORM_BITS-1:0] d_q;
    logic signed [15:0]   d_res;

    always_comb begin
        d_sh  = {r_rem[LW:0], 1'b0};
        d_ge  = (d_sh >= (LW + 2)'(r_den));
        d_q   = {r_q[NORM_BITS-2:0], d_ge};
        d_res = r_neg ? -$signed({1'b0, d_q}) : $signed({1'b0, d_q});
    end

    // slicer and phase
    logic signed [17:0]    p_d, p_h;
    logic [PHASE_BITS-1:0] p_pc;
    logic                  p_wrap;
    logic [CW-1:0]         p_pg, p_pb, p_score;
    logic                  p_det;
    logic                  p_inside;
    logic [PHASE_BITS-1:0] p_adj;

    always_comb begin
        p_d      = 18'(r_nm) - 18'(r_ns);
        p_h      = $signed(18'(r_hyst));
        p_pc     = r_phase + PHASE_BITS'(r_step);
        p_wrap   = p_pc[PHASE_BITS-1] & ~r_phase[PHASE_BITS-1] & (r_phase != '0);
        p_pg     = f_pop(r_good_h);
        p_pb     = f_pop(r_bad_h);
        p_det    = ((CW + 1)'(p_pg) >= (CW + 1)'(p_pb) + (CW + 1)'(DETECT_MARGIN));
        p_score  = f_pop(r_det_h);
        p_inside = r_phase[PHASE_BITS-1] ? (r_phase > HALF_WINDOW_LO)
                                         : (r_phase < HALF_WINDOW_HI);
        p_adj    = r_carrier ? PHASE_BITS'($signed(r_phase) >>> LOCKED_SHIFT)
                             : PHASE_BITS'($signed(r_phase) >>> SEARCH_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_side      <= 1'b0;
            r_cnt       <= '0;
            r_mh        <= '0;
            r_ml        <= '0;
            r_sh        <= '0;
            r_sl        <= '0;
            r_sym       <= 1'b0;
            r_prev_sym  <= 1'b0;
            r_phase     <= '0;
            r_good_p    <= 1'b0;
            r_bad_p     <= 1'b0;
            r_good_h    <= '0;
            r_bad_h     <= '0;
            r_det_h     <= '0;
            r_carrier   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != ST_CAR) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_xm    <= {LEVEL_BITS'(i_in_word.mark_level), {FRAC_BITS{1'b0}}};
                        r_xs    <= {LEVEL_BITS'(i_in_word.space_level), {FRAC_BITS{1'b0}}};
                        r_idx   <= '0;
                        r_state <= ST_MHI;
                    end
                end
                ST_MHI: begin
                    r_acc   <= LW'(t_prd);
                    r_state <= ST_MLO;
                end
                ST_MLO: begin
                    r_prod  <= (2 * COEF_BITS)'(t_prd);
                    r_state <= ST_TRK;
                end
                ST_TRK: begin
                    unique case (r_idx)
                        2'd0:    r_mh <= t_new;
                        2'd1:    r_ml <= t_new;
                        2'd2:    r_sh <= t_new;
                        default: r_sl <= t_new;
                    endcase
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        r_side  <= 1'b0;
                        r_state <= ST_NSET;
                    end else begin
                        r_state <= ST_MHI;
                    end
                end
                ST_NSET: begin
                    r_neg <= s_neg;
                    r_den <= s_den;
                    r_rem <= (LW + 2)'(s_mag);
                    r_q   <= '0;
                    r_cnt <= '0;
                    if (s_hi <= s_lo || s_mag >= s_den) begin
                        if (r_side) begin
                            r_ns    <= (s_hi <= s_lo) ? 16'sh0000
                                                      : (s_neg ? 16'sh8000 : 16'sh7FFF);
                            r_state <= ST_PH;
                        end else begin
                            r_nm    <= (s_hi <= s_lo) ? 16'sh0000
                                                      : (s_neg ? 16'sh8000 : 16'sh7FFF);
                            r_side  <= 1'b1;
                        end
                    end else begin
                        r_state <= ST_NDIV;
                    end
                end
                ST_NDIV: begin
                    r_rem <= d_ge ? (d_sh - (LW + 2)'(r_den)) : d_sh;
                    r_q   <= d_q;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'(NORM_BITS - 1)) begin
                        if (r_side) begin
                            r_ns    <= d_res;
                            r_state <= ST_PH;
                        end else begin
                            r_nm    <= d_res;
                            r_side  <= 1'b1;
                            r_state <= ST_NSET;
                        end
                    end
                end
                ST_PH: begin
                    r_prev_sym <= r_sym;
                    if (p_d > p_h) begin
                        r_sym <= 1'b1;
                    end else if (-p_d > p_h) begin
                        r_sym <= 1'b0;
                    end
                    r_phase <= p_pc;
                    if (p_wrap) begin
                        r_good_h <= {r_good_h[HISTORY_BITS-2:0], r_good_p};
                        r_bad_h  <= {r_bad_h[HISTORY_BITS-2:0], r_bad_p};
                        r_good_p <= 1'b0;
                        r_bad_p  <= 1'b0;
                        r_state  <= ST_DET;
                    end else begin
                        r_state  <= ST_TRN;
                    end
                end
                ST_DET: begin
                    r_det_h <= {r_det_h[HISTORY_BITS-2:0], p_det};
                    r_state <= ST_CAR;
                end
                ST_CAR: begin
                    if (!r_out_valid || i_out_ready) begin
                        if (!r_carrier && (CW + 1)'(p_score) > (CW + 1)'(r_car_on)) begin
                            r_carrier                <= 1'b1;
                            r_out.carrier_detect     <= 1'b1;
                            r_out.data_bit           <= r_sym;
                        end else if (r_carrier &&
                                     (CW + 1)'(p_score) < (CW + 1)'(r_car_off)) begin
                            r_carrier                <= 1'b0;
                            r_out.carrier_detect     <= 1'b0;
                            r_out.data_bit           <= 1'b1;
                        end else begin
                            r_out.carrier_detect     <= r_carrier;
                            r_out.data_bit           <= r_carrier ? r_sym : 1'b1;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= ST_TRN;
                    end
                end
                ST_TRN: begin
                    if (r_sym != r_prev_sym) begin
                        if (p_inside) begin
                            r_good_p <= 1'b1;
                        end else begin
                            r_bad_p  <= 1'b1;
                        end
                        r_phase <= r_phase - p_adj;
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
